>>> rtl/sal_pkg.sv
// Shared types and codes for the shifting array list.
// No dependencies; every other file in rtl/ imports this package.
package sal_pkg;

   localparam int unsigned POS_WIDTH   = 4;
   localparam int unsigned VALUE_WIDTH = 32;
   localparam int unsigned FILL_WIDTH  = 5;

   typedef enum logic [3:0] {
      ACT_PUSH_BACK  = 4'd0,
      ACT_PUSH_FRONT = 4'd1,
      ACT_POP_BACK   = 4'd2,
      ACT_POP_FRONT  = 4'd3,
      ACT_INSERT     = 4'd4,
      ACT_REMOVE     = 4'd5,
      ACT_ASSIGN     = 4'd6,
      ACT_READ_AT    = 4'd7,
      ACT_READ_FRONT = 4'd8,
      ACT_READ_BACK  = 4'd9,
      ACT_CLEAR      = 4'd10
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic [3:0]             action;
      logic [POS_WIDTH-1:0]   position;
      logic [VALUE_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [VALUE_WIDTH-1:0] read_value;
      logic [FILL_WIDTH-1:0]  fill_count;
   } rsp_type;

   // controller -> datapath commands
   typedef struct packed {
      logic capture;  // latch the incoming request
      logic execute;  // apply the latched request, load the response register
   } ctl_type;

endpackage

>>> rtl/sal_ctrl.sv
// Controller FSM for the shifting array list: handshakes and sequencing.
// Depends on sal_pkg.
module sal_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output sal_pkg::ctl_type ctl
);
   import sal_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      ctl.capture = 1'b0;
      ctl.execute = 1'b0;
      req_stall   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            // wait until the response register is free or being drained
            if (!rsp_valid_ff || !rsp_stall) begin
               ctl.execute = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = ctl.execute | (rsp_valid_ff & rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/sal_dpath.sv
// Datapath for the shifting array list: request latch, entry cells with
// neighbor shifting, count register and response register. Depends on sal_pkg.
module sal_dpath #(
   parameter int unsigned CAPACITY   = 16,
   parameter int unsigned ELEM_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  sal_pkg::ctl_type ctl,
   input  sal_pkg::req_type req_data,
   output sal_pkg::rsp_type rsp_data
);
   import sal_pkg::*;

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned PW = (CW > POS_WIDTH) ? CW : POS_WIDTH;

   req_type                cmd_ff;
   rsp_type                rsp_ff, rsp_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [ELEM_WIDTH-1:0]  entries_ff [CAPACITY];
   logic [ELEM_WIDTH-1:0]  entries_in [CAPACITY];

   logic [PW-1:0]                  pos_ext, cnt_ext, rd_idx;
   logic [ELEM_WIDTH+VALUE_WIDTH-1:0] word_wide;
   logic [ELEM_WIDTH+VALUE_WIDTH-1:0] rd_wide;
   logic [CW+FILL_WIDTH-1:0]       fill_wide;
   logic [ELEM_WIDTH-1:0]          word, rd_sel;
   logic                           full, empty, in_list, ok, do_read;
   status_type                     status;

   always_ff @(posedge clock) begin
      if (ctl.capture) cmd_ff <= req_data;
      if (ctl.execute) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else       count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) entries_ff[i] <= entries_in[i];
   end

   assign pos_ext   = PW'(cmd_ff.position);
   assign cnt_ext   = PW'(count_ff);
   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign in_list   = (pos_ext < cnt_ext);
   assign word_wide = {{ELEM_WIDTH{1'b0}}, cmd_ff.value};
   assign word      = word_wide[ELEM_WIDTH-1:0];

   // status and count update
   always_comb begin
      status   = ST_OK;
      do_read  = 1'b0;
      count_in = count_ff;
      rd_idx   = pos_ext;
      unique case (cmd_ff.action)
         ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
            if (full) status = ST_FULL;
         end
         ACT_POP_BACK, ACT_POP_FRONT: begin
            if (empty) status = ST_EMPTY;
         end
         ACT_INSERT: begin
            if (full)          status = ST_FULL;
            else if (!in_list) status = ST_RANGE;
         end
         ACT_REMOVE, ACT_ASSIGN: begin
            if (empty)         status = ST_EMPTY;
            else if (!in_list) status = ST_RANGE;
         end
         ACT_READ_AT: begin
            if (!in_list) status = ST_RANGE;
            do_read = 1'b1;
         end
         ACT_READ_FRONT: begin
            if (empty) status = ST_EMPTY;
            rd_idx  = '0;
            do_read = 1'b1;
         end
         ACT_READ_BACK: begin
            if (empty) status = ST_EMPTY;
            rd_idx  = cnt_ext - PW'(1);
            do_read = 1'b1;
         end
         default: ;
      endcase
      ok = (status == ST_OK);
      if (ctl.execute && ok) begin
         unique case (cmd_ff.action)
            ACT_PUSH_BACK, ACT_PUSH_FRONT, ACT_INSERT: count_in = count_ff + CW'(1);
            ACT_POP_BACK, ACT_POP_FRONT, ACT_REMOVE:   count_in = count_ff - CW'(1);
            ACT_CLEAR:                                 count_in = '0;
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      rd_sel = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (rd_idx == PW'(i)) rd_sel = entries_ff[i];
      end
   end

   assign rd_wide   = {{VALUE_WIDTH{1'b0}}, ((do_read && ok) ? rd_sel : '0)};
   assign fill_wide = {{FILL_WIDTH{1'b0}}, count_in};

   always_comb begin
      rsp_in.status     = status;
      rsp_in.read_value = rd_wide[VALUE_WIDTH-1:0];
      rsp_in.fill_count = fill_wide[FILL_WIDTH-1:0];
   end

   // each cell picks its next word from itself, a neighbor or the request
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ELEM_WIDTH-1:0] prev_word, next_word;
      logic                  at_pos, past_pos, at_cnt;

      if (i == 0) begin : g_first
         assign prev_word = word;
      end else begin : g_mid
         assign prev_word = entries_ff[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_word = entries_ff[i];
      end else begin : g_inner
         assign next_word = entries_ff[i+1];
      end

      assign at_pos   = (pos_ext == PW'(i));
      assign past_pos = (pos_ext < PW'(i));
      assign at_cnt   = (cnt_ext == PW'(i));

      always_comb begin
         entries_in[i] = entries_ff[i];
         if (ctl.execute && ok) begin
            unique case (cmd_ff.action)
               ACT_PUSH_BACK:  if (at_cnt) entries_in[i] = word;
               ACT_PUSH_FRONT: entries_in[i] = prev_word;
               ACT_POP_FRONT:  entries_in[i] = next_word;
               ACT_INSERT: begin
                  if (at_pos)        entries_in[i] = word;
                  else if (past_pos) entries_in[i] = prev_word;
               end
               ACT_REMOVE:     if (at_pos || past_pos) entries_in[i] = next_word;
               ACT_ASSIGN:     if (at_pos) entries_in[i] = word;
               default: ;
            endcase
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> rtl/shifting_array_list.sv
// Top level of the shifting array list: controller plus datapath.
// Depends on sal_pkg, sal_ctrl and sal_dpath.
//
//   channel   direction  handshake                payload
//   req_      in         req_valid / req_stall    req_data  (action, position, value)
//   rsp_      out        rsp_valid / rsp_stall    rsp_data  (status, read_value, fill_count)
//
// Each request is first latched, then run through the entry cells, which
// all shift in parallel. A new request is taken while the previous
// response still waits. If the response register is still held by
// rsp_stall, execution waits. Reset is synchronous and empties the list.
module shifting_array_list #(
   parameter int unsigned CAPACITY   = 16,
   parameter int unsigned ELEM_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sal_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sal_pkg::rsp_type rsp_data
);
   import sal_pkg::*;

   ctl_type ctl;

   sal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   sal_dpath #(
      .CAPACITY   (CAPACITY),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
